// ----- hw/rtl/sbc_pkg.sv -----
// Shared types and constants for the sphere/box contact pipeline.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package sbc_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int EXT_W   = COORD_W - 1;
    localparam int HALF_W  = EXT_W - 1;
    localparam int WIDE_W  = COORD_W + 1;
    localparam int DIFF_W  = COORD_W + 2;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int DSQ_W   = 2 * EXT_W;
    localparam int DIST_W  = EXT_W;
    localparam int MAG_W   = EXT_W;
    localparam int DEP_W   = DIFF_W;
    localparam int PEN_W   = DIFF_W + 1;
    localparam int Q_W     = FRAC_W + 1;
    localparam int NORM_W  = FRAC_W + 2;
    localparam int NUM_W   = MAG_W + FRAC_W;
    localparam int PROD_W  = DIST_W + Q_W;
    localparam int EPS_W   = 32;

    localparam logic [EPS_W-1:0] EPS_RESET = 32'd4295;
    localparam logic signed [NORM_W-1:0] NORM_ONE = {2'b01, {FRAC_W{1'b0}}};

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sphere_x;
        logic signed [COORD_W-1:0] sphere_y;
        logic signed [COORD_W-1:0] sphere_z;
        logic        [EXT_W-1:0]   sphere_radius;
        logic signed [COORD_W-1:0] box_x;
        logic signed [COORD_W-1:0] box_y;
        logic signed [COORD_W-1:0] box_z;
        logic        [EXT_W-1:0]   box_width;
        logic        [EXT_W-1:0]   box_height;
        logic        [EXT_W-1:0]   box_length;
    } in_t;

    typedef struct packed {
        logic                     hit;
        logic                     in_box;
        axis_t                    ax;
        logic                     ax_pos;
        logic [2:0]               d_neg;
        logic [2:0][MAG_W-1:0]    d_mag;
        logic [DSQ_W-1:0]         dsq;
        logic [EXT_W-1:0]         r;
        logic signed [PEN_W-1:0]  pen_in;
    } front_t;

    typedef struct packed {
        logic                     hit;
        logic                     in_box;
        axis_t                    ax;
        logic                     ax_pos;
        logic [2:0]               d_neg;
        logic [2:0][MAG_W-1:0]    d_mag;
        logic [EXT_W-1:0]         r;
        logic signed [PEN_W-1:0]  pen_in;
    } sq_side_t;

    typedef struct packed {
        logic                     hit;
        logic                     in_box;
        axis_t                    ax;
        logic                     ax_pos;
        logic [2:0]               d_neg;
        logic [DIST_W-1:0]        pen_out;
        logic signed [PEN_W-1:0]  pen_in;
    } dv_side_t;

    typedef struct packed {
        logic                      hit;
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [NORM_W-1:0]  normal_y;
        logic signed [NORM_W-1:0]  normal_z;
        logic signed [COORD_W-1:0] push_x;
        logic signed [COORD_W-1:0] push_y;
        logic signed [COORD_W-1:0] push_z;
    } out_t;

endpackage

// ----- hw/rtl/sbc_in_if.sv -----
// Input channel of the sphere/box contact block: valid/ready plus one pair.
// Depends on sbc_pkg for field widths.
`timescale 1ns / 1ps

interface sbc_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [sbc_pkg::COORD_W-1:0]       sphere_x;
    logic signed [sbc_pkg::COORD_W-1:0]       sphere_y;
    logic signed [sbc_pkg::COORD_W-1:0]       sphere_z;
    logic        [sbc_pkg::EXT_W-1:0]         sphere_radius;
    logic signed [sbc_pkg::COORD_W-1:0]       box_x;
    logic signed [sbc_pkg::COORD_W-1:0]       box_y;
    logic signed [sbc_pkg::COORD_W-1:0]       box_z;
    logic        [sbc_pkg::EXT_W-1:0]         box_width;
    logic        [sbc_pkg::EXT_W-1:0]         box_height;
    logic        [sbc_pkg::EXT_W-1:0]         box_length;

    modport source (
        output valid, sphere_x, sphere_y, sphere_z, sphere_radius,
               box_x, box_y, box_z, box_width, box_height, box_length,
        input  ready
    );
    modport sink (
        input  valid, sphere_x, sphere_y, sphere_z, sphere_radius,
               box_x, box_y, box_z, box_width, box_height, box_length,
        output ready
    );
endinterface

// ----- hw/rtl/sbc_out_if.sv -----
// Result channel of the sphere/box contact block: valid/ready plus one contact.
// Depends on sbc_pkg for field widths.
`timescale 1ns / 1ps

interface sbc_out_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic signed [sbc_pkg::NORM_W-1:0]   normal_x;
    logic signed [sbc_pkg::NORM_W-1:0]   normal_y;
    logic signed [sbc_pkg::NORM_W-1:0]   normal_z;
    logic signed [sbc_pkg::COORD_W-1:0]  push_x;
    logic signed [sbc_pkg::COORD_W-1:0]  push_y;
    logic signed [sbc_pkg::COORD_W-1:0]  push_z;

    modport source (
        output valid, hit, normal_x, normal_y, normal_z, push_x, push_y, push_z,
        input  ready
    );
    modport sink (
        input  valid, hit, normal_x, normal_y, normal_z, push_x, push_y, push_z,
        output ready
    );
endinterface

// ----- hw/rtl/sphere_box_contact.sv -----
// Sphere against axis-aligned box contact test, top level.
// Depends on sbc_pkg, sbc_in_if, sbc_out_if, sbc_front, sbc_isqrt, sbc_div, sbc_back.
`timescale 1ns / 1ps
//
// Usage:
//   in_item  : valid/ready channel, one sphere and one box per transfer.
//   out_item : valid/ready channel, one contact result per input transfer,
//              in input order (hit flag, unit normal, push-out vector).
//   cfg_we / cfg_wdata : write inside_epsilon; change it only while idle.
// Path: a result passes the front stages, the square root, the divider, the
//   back stages and the output buffer, in that order, after its input transfer.
// Throughput: one item per cycle while out_item keeps taking results; nothing in the datapath loops.
// Reset: clears all valid bits and the output buffer, and loads
//   inside_epsilon with its default of 4295.
// Stall: the whole pipeline advances on one enable that depends only on the
//   fill of a two-entry output buffer, so in_item.ready never waits on
//   out_item.ready combinationally. While one result waits, the pipe keeps
//   taking items; it freezes only when both entries are held.

module sphere_box_contact (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sbc_pkg::EPS_W-1:0]     cfg_wdata,
    sbc_in_if.sink                        in_item,
    sbc_out_if.source                     out_item
);

    localparam int SKID_DEPTH = 2;
    localparam int CNT_W      = $clog2(SKID_DEPTH + 1);

    // configuration register
    logic [sbc_pkg::EPS_W-1:0] eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= sbc_pkg::EPS_RESET;
        else if (cfg_we)
            eps_reg <= cfg_wdata;
    end

    // global advance: hold every stage when the output buffer is full
    logic [CNT_W-1:0] cnt_reg;
    logic             adv;

    assign adv           = (cnt_reg != CNT_W'(SKID_DEPTH));
    assign in_item.ready = adv;

    // pack the input transfer
    sbc_pkg::in_t in_data;

    always_comb
    begin
        in_data.sphere_x      = in_item.sphere_x;
        in_data.sphere_y      = in_item.sphere_y;
        in_data.sphere_z      = in_item.sphere_z;
        in_data.sphere_radius = in_item.sphere_radius;
        in_data.box_x         = in_item.box_x;
        in_data.box_y         = in_item.box_y;
        in_data.box_z         = in_item.box_z;
        in_data.box_width     = in_item.box_width;
        in_data.box_height    = in_item.box_height;
        in_data.box_length    = in_item.box_length;
    end

    // clamp, squared distance, hit and inside decisions
    logic            fr_valid;
    sbc_pkg::front_t fr_data;

    sbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_item.valid),
        .in_data   (in_data),
        .eps       (eps_reg),
        .out_valid (fr_valid),
        .out_data  (fr_data)
    );

    // distance = floor(sqrt(squared distance)); the rest rides along
    localparam int SQ_SIDE_W = $bits(sbc_pkg::sq_side_t);

    sbc_pkg::sq_side_t              sq_in_side;
    logic [SQ_SIDE_W-1:0]           sq_out_bits;
    sbc_pkg::sq_side_t              sq_side;
    logic                           sq_valid;
    logic [sbc_pkg::DIST_W-1:0]     sq_dist;

    always_comb
    begin
        sq_in_side.hit    = fr_data.hit;
        sq_in_side.in_box = fr_data.in_box;
        sq_in_side.ax     = fr_data.ax;
        sq_in_side.ax_pos = fr_data.ax_pos;
        sq_in_side.d_neg  = fr_data.d_neg;
        sq_in_side.d_mag  = fr_data.d_mag;
        sq_in_side.r      = fr_data.r;
        sq_in_side.pen_in = fr_data.pen_in;
    end

    sbc_isqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (fr_valid),
        .in_dsq    (fr_data.dsq),
        .in_side   (sq_in_side),
        .out_valid (sq_valid),
        .out_dist  (sq_dist),
        .out_side  (sq_out_bits)
    );

    assign sq_side = sbc_pkg::sq_side_t'(sq_out_bits);

    // normal components = |d| / distance; penetration taken here
    localparam int DV_SIDE_W = $bits(sbc_pkg::dv_side_t);

    sbc_pkg::dv_side_t                  dv_in_side;
    logic [DV_SIDE_W-1:0]               dv_out_bits;
    sbc_pkg::dv_side_t                  dv_side;
    logic                               dv_valid;
    logic [2:0][sbc_pkg::Q_W-1:0]       dv_quo;

    always_comb
    begin
        dv_in_side.hit     = sq_side.hit;
        dv_in_side.in_box  = sq_side.in_box;
        dv_in_side.ax      = sq_side.ax;
        dv_in_side.ax_pos  = sq_side.ax_pos;
        dv_in_side.d_neg   = sq_side.d_neg;
        dv_in_side.pen_out = sq_side.r - sq_dist;
        dv_in_side.pen_in  = sq_side.pen_in;
    end

    sbc_div #(
        .SIDE_W (DV_SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq_valid),
        .in_num    (sq_side.d_mag),
        .in_den    (sq_dist),
        .in_side   (dv_in_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_out_bits)
    );

    assign dv_side = sbc_pkg::dv_side_t'(dv_out_bits);

    // push scaling and result assembly
    logic          bk_valid;
    sbc_pkg::out_t bk_data;

    sbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (dv_valid),
        .in_quo    (dv_quo),
        .in_side   (dv_side),
        .out_valid (bk_valid),
        .out_data  (bk_data)
    );

    // two-entry output buffer; a transfer leaves from the head entry
    sbc_pkg::out_t    skid_reg [SKID_DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;
    sbc_pkg::out_t    head;

    assign push = adv && bk_valid;
    assign pop  = out_item.valid && out_item.ready;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            skid_reg[wr_ptr_reg] <= bk_data;
    end

    assign head = skid_reg[rd_ptr_reg];

    assign out_item.valid    = (cnt_reg != '0);
    assign out_item.hit      = head.hit;
    assign out_item.normal_x = head.normal_x;
    assign out_item.normal_y = head.normal_y;
    assign out_item.normal_z = head.normal_z;
    assign out_item.push_x   = head.push_x;
    assign out_item.push_y   = head.push_y;
    assign out_item.push_z   = head.push_z;

`ifndef SYNTHESIS
    // the buffer never takes a result it has no room for
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == CNT_W'(SKID_DEPTH)) |-> !push)
        else $error("output buffer overflow");

    // a miss carries an all-zero contact
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && !out_item.hit) |->
        (out_item.normal_x == '0 && out_item.normal_y == '0 && out_item.normal_z == '0 &&
         out_item.push_x == '0 && out_item.push_y == '0 && out_item.push_z == '0))
        else $error("miss with nonzero contact");

    // a hit always has some normal direction
    a_hit_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && out_item.hit) |->
        (out_item.normal_x != '0 || out_item.normal_y != '0 || out_item.normal_z != '0))
        else $error("hit with zero normal");

    // normal components stay within one unit
    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_item.valid |->
        (out_item.normal_x <= sbc_pkg::NORM_ONE && out_item.normal_x >= -sbc_pkg::NORM_ONE &&
         out_item.normal_y <= sbc_pkg::NORM_ONE && out_item.normal_y >= -sbc_pkg::NORM_ONE &&
         out_item.normal_z <= sbc_pkg::NORM_ONE && out_item.normal_z >= -sbc_pkg::NORM_ONE))
        else $error("normal component out of range");
`endif

endmodule

// ----- hw/rtl/sbc_front.sv -----
// Front stages: clamp to the box, squared distance, hit and inside tests,
// least-depth axis. Six register stages. Depends on sbc_pkg.
`timescale 1ns / 1ps

module sbc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  sbc_pkg::in_t                in_data,
    input  logic [sbc_pkg::EPS_W-1:0]   eps,
    output logic                        out_valid,
    output sbc_pkg::front_t             out_data
);

    localparam int STAGES  = 6;
    localparam int COORD_W = sbc_pkg::COORD_W;
    localparam int EXT_W   = sbc_pkg::EXT_W;
    localparam int HALF_W  = sbc_pkg::HALF_W;
    localparam int WIDE_W  = sbc_pkg::WIDE_W;
    localparam int DIFF_W  = sbc_pkg::DIFF_W;
    localparam int SQ_W    = sbc_pkg::SQ_W;
    localparam int SUM_W   = sbc_pkg::SUM_W;
    localparam int DSQ_W   = sbc_pkg::DSQ_W;
    localparam int MAG_W   = sbc_pkg::MAG_W;
    localparam int DEP_W   = sbc_pkg::DEP_W;
    localparam int PEN_W   = sbc_pkg::PEN_W;

    logic [STAGES-1:0] v_reg;

    logic signed [COORD_W-1:0] s_in [3];
    logic signed [COORD_W-1:0] b_in [3];
    logic        [EXT_W-1:0]   ext_in [3];

    assign s_in[0]   = in_data.sphere_x;
    assign s_in[1]   = in_data.sphere_y;
    assign s_in[2]   = in_data.sphere_z;
    assign b_in[0]   = in_data.box_x;
    assign b_in[1]   = in_data.box_y;
    assign b_in[2]   = in_data.box_z;
    assign ext_in[0] = in_data.box_width;
    assign ext_in[1] = in_data.box_height;
    assign ext_in[2] = in_data.box_length;

    // stage 1: box bounds and center offset
    logic        [HALF_W-1:0]  half1_next [3];
    logic signed [WIDE_W-1:0]  lo1_next [3];
    logic signed [WIDE_W-1:0]  hi1_next [3];
    logic signed [WIDE_W-1:0]  t1_next [3];
    logic signed [COORD_W-1:0] s1_reg [3];
    logic        [HALF_W-1:0]  half1_reg [3];
    logic signed [WIDE_W-1:0]  lo1_reg [3];
    logic signed [WIDE_W-1:0]  hi1_reg [3];
    logic signed [WIDE_W-1:0]  t1_reg [3];
    logic        [EXT_W-1:0]   r1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            half1_next[i] = ext_in[i][EXT_W-1:1];
            lo1_next[i]   = WIDE_W'(b_in[i]) - $signed(WIDE_W'(half1_next[i]));
            hi1_next[i]   = WIDE_W'(b_in[i]) + $signed(WIDE_W'(half1_next[i]));
            t1_next[i]    = WIDE_W'(s_in[i]) - WIDE_W'(b_in[i]);
        end
    end

    // stage 2: clamp and difference to the closest point
    logic signed [WIDE_W-1:0] c2 [3];
    logic signed [DIFF_W-1:0] d2_next [3];
    logic        [WIDE_W-1:0] tmag2_next [3];
    logic [2:0]               tpos2_next;
    logic signed [DIFF_W-1:0] d2_reg [3];
    logic        [WIDE_W-1:0] tmag2_reg [3];
    logic [2:0]               tpos2_reg;
    logic        [HALF_W-1:0] half2_reg [3];
    logic        [EXT_W-1:0]  r2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            priority if (WIDE_W'(s1_reg[i]) < lo1_reg[i])
                c2[i] = lo1_reg[i];
            else if (WIDE_W'(s1_reg[i]) > hi1_reg[i])
                c2[i] = hi1_reg[i];
            else
                c2[i] = WIDE_W'(s1_reg[i]);
            d2_next[i]    = DIFF_W'(s1_reg[i]) - DIFF_W'(c2[i]);
            tmag2_next[i] = t1_reg[i][WIDE_W-1] ? WIDE_W'(-t1_reg[i]) : WIDE_W'(t1_reg[i]);
            tpos2_next[i] = !t1_reg[i][WIDE_W-1] && (t1_reg[i] != '0);
        end
    end

    // stage 3: magnitudes, saturation flags, depths
    logic        [DIFF_W-1:0]  dmag3 [3];
    logic        [COORD_W-1:0] m3_next [3];
    logic [2:0]                sat3_next;
    logic [2:0]                dneg3_next;
    logic signed [DEP_W-1:0]   dep3_next [3];
    logic        [COORD_W-1:0] m3_reg [3];
    logic [2:0]                sat3_reg;
    logic [2:0]                dneg3_reg;
    logic signed [DEP_W-1:0]   dep3_reg [3];
    logic [2:0]                tpos3_reg;
    logic        [EXT_W-1:0]   r3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dmag3[i]      = d2_reg[i][DIFF_W-1] ? DIFF_W'(-d2_reg[i]) : DIFF_W'(d2_reg[i]);
            m3_next[i]    = dmag3[i][COORD_W-1:0];
            sat3_next[i]  = |dmag3[i][DIFF_W-1:COORD_W];
            dneg3_next[i] = d2_reg[i][DIFF_W-1];
            dep3_next[i]  = $signed(DEP_W'(half2_reg[i])) - $signed(DEP_W'(tmag2_reg[i]));
        end
    end

    // stage 4: squares
    logic [SQ_W-1:0]        sq4_next [3];
    logic [DSQ_W-1:0]       rsq4_next;
    logic [SQ_W-1:0]        sq4_reg [3];
    logic [DSQ_W-1:0]       rsq4_reg;
    logic [2:0]             sat4_reg;
    logic [2:0]             dneg4_reg;
    logic [2:0][MAG_W-1:0]  mag4_reg;
    logic signed [DEP_W-1:0] dep4_reg [3];
    logic [2:0]             tpos4_reg;
    logic [EXT_W-1:0]       r4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq4_next[i] = SQ_W'(m3_reg[i]) * SQ_W'(m3_reg[i]);
        rsq4_next = DSQ_W'(r3_reg) * DSQ_W'(r3_reg);
    end

    // stage 5: sum of squares and least-depth axis
    logic [SUM_W-1:0]        sum5_next;
    sbc_pkg::axis_t          ax5_next;
    logic signed [DEP_W-1:0] depax5_next;
    logic [SUM_W-1:0]        sum5_reg;
    logic                    sat5_reg;
    logic [DSQ_W-1:0]        rsq5_reg;
    sbc_pkg::axis_t          ax5_reg;
    logic                    axpos5_reg;
    logic signed [DEP_W-1:0] depax5_reg;
    logic [2:0]              dneg5_reg;
    logic [2:0][MAG_W-1:0]   mag5_reg;
    logic [EXT_W-1:0]        r5_reg;

    always_comb
    begin
        sum5_next = SUM_W'(sq4_reg[0]) + SUM_W'(sq4_reg[1]) + SUM_W'(sq4_reg[2]);
        // x only when strictly least, then y only when strictly below z, else z
        priority if (dep4_reg[0] < dep4_reg[1] && dep4_reg[0] < dep4_reg[2])
            ax5_next = sbc_pkg::AX_X;
        else if (dep4_reg[1] < dep4_reg[2])
            ax5_next = sbc_pkg::AX_Y;
        else
            ax5_next = sbc_pkg::AX_Z;
        unique case (ax5_next)
            sbc_pkg::AX_X: depax5_next = dep4_reg[0];
            sbc_pkg::AX_Y: depax5_next = dep4_reg[1];
            default:       depax5_next = dep4_reg[2];
        endcase
    end

    // stage 6: hit and inside decisions
    sbc_pkg::front_t out_next;
    sbc_pkg::front_t out_data_reg;

    always_comb
    begin
        out_next.hit    = !sat5_reg && (sum5_reg < SUM_W'(rsq5_reg));
        out_next.in_box = (sum5_reg < SUM_W'(eps)) || (sum5_reg == '0);
        out_next.ax     = ax5_reg;
        out_next.ax_pos = axpos5_reg;
        out_next.d_neg  = dneg5_reg;
        out_next.d_mag  = mag5_reg;
        out_next.dsq    = sum5_reg[DSQ_W-1:0];
        out_next.r      = r5_reg;
        out_next.pen_in = $signed(PEN_W'(r5_reg)) - PEN_W'(depax5_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_reg[i]    <= s_in[i];
                half1_reg[i] <= half1_next[i];
                lo1_reg[i]   <= lo1_next[i];
                hi1_reg[i]   <= hi1_next[i];
                t1_reg[i]    <= t1_next[i];
                d2_reg[i]    <= d2_next[i];
                tmag2_reg[i] <= tmag2_next[i];
                half2_reg[i] <= half1_reg[i];
                m3_reg[i]    <= m3_next[i];
                dep3_reg[i]  <= dep3_next[i];
                sq4_reg[i]   <= sq4_next[i];
                mag4_reg[i]  <= m3_reg[i][MAG_W-1:0];
                dep4_reg[i]  <= dep3_reg[i];
            end
            r1_reg     <= in_data.sphere_radius;
            tpos2_reg  <= tpos2_next;
            r2_reg     <= r1_reg;
            sat3_reg   <= sat3_next;
            dneg3_reg  <= dneg3_next;
            tpos3_reg  <= tpos2_reg;
            r3_reg     <= r2_reg;
            rsq4_reg   <= rsq4_next;
            sat4_reg   <= sat3_reg;
            dneg4_reg  <= dneg3_reg;
            tpos4_reg  <= tpos3_reg;
            r4_reg     <= r3_reg;
            sum5_reg   <= sum5_next;
            sat5_reg   <= |sat4_reg;
            rsq5_reg   <= rsq4_reg;
            ax5_reg    <= ax5_next;
            axpos5_reg <= tpos4_reg[ax5_next];
            depax5_reg <= depax5_next;
            dneg5_reg  <= dneg4_reg;
            mag5_reg   <= mag4_reg;
            r5_reg     <= r4_reg;
            out_data_reg <= out_next;
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_data  = out_data_reg;

endmodule

// ----- hw/rtl/sbc_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on sbc_pkg for the operand width.
`timescale 1ns / 1ps

module sbc_isqrt #(
    parameter int SIDE_W = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [sbc_pkg::DSQ_W-1:0]    in_dsq,
    input  logic [SIDE_W-1:0]            in_side,
    output logic                         out_valid,
    output logic [sbc_pkg::DIST_W-1:0]   out_dist,
    output logic [SIDE_W-1:0]            out_side
);

    localparam int W     = sbc_pkg::DSQ_W;
    localparam int STEPS = W / 2;

    logic [W-1:0]      v_reg [STEPS];
    logic [W-1:0]      res_reg [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    logic [STEPS-1:0]  val_reg;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
        logic [W-1:0]      v_in;
        logic [W-1:0]      res_in;
        logic [SIDE_W-1:0] side_in;
        logic              val_in;
        logic [W-1:0]      trial;
        logic              ge;
        logic [W-1:0]      v_next;
        logic [W-1:0]      res_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_dsq;
            assign res_in  = '0;
            assign side_in = in_side;
            assign val_in  = in_valid;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_in = side_reg[k-1];
            assign val_in  = val_reg[k-1];
        end

        always_comb
        begin
            trial    = res_in + BIT;
            ge       = v_in >= trial;
            v_next   = ge ? v_in - trial : v_in;
            res_next = ge ? (res_in >> 1) + BIT : res_in >> 1;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                val_reg[k] <= 1'b0;
            else if (en)
                val_reg[k] <= val_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]    <= v_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = val_reg[STEPS-1];
    assign out_dist  = res_reg[STEPS-1][sbc_pkg::DIST_W-1:0];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ----- hw/rtl/sbc_div.sv -----
// Three-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage, with sideband. Depends on sbc_pkg for widths.
`timescale 1ns / 1ps

module sbc_div #(
    parameter int SIDE_W = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [2:0][sbc_pkg::MAG_W-1:0]       in_num,
    input  logic [sbc_pkg::DIST_W-1:0]           in_den,
    input  logic [SIDE_W-1:0]                    in_side,
    output logic                                 out_valid,
    output logic [2:0][sbc_pkg::Q_W-1:0]         out_quo,
    output logic [SIDE_W-1:0]                    out_side
);

    localparam int QW    = sbc_pkg::Q_W;
    localparam int DW    = sbc_pkg::DIST_W;
    localparam int NW    = sbc_pkg::NUM_W;
    localparam int FW    = sbc_pkg::FRAC_W;

    logic [2:0][DW-1:0] rem0;
    logic [2:0][QW-1:0] low0;
    logic [NW-1:0]      num_full [3];

    // quotient is known to fit QW bits, so the top bits start below the divisor
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            num_full[l] = {in_num[l], {FW{1'b0}}};
            rem0[l]     = DW'(num_full[l] >> QW);
            low0[l]     = num_full[l][QW-1:0];
        end
    end

    logic [2:0][DW-1:0] rem_reg [QW];
    logic [2:0][QW-1:0] low_reg [QW];
    logic [2:0][QW-1:0] quo_reg [QW];
    logic [DW-1:0]      den_reg [QW];
    logic [SIDE_W-1:0]  side_reg [QW];
    logic [QW-1:0]      val_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [2:0][DW-1:0] rem_in;
        logic [2:0][QW-1:0] low_in;
        logic [2:0][QW-1:0] quo_in;
        logic [DW-1:0]      den_in;
        logic [SIDE_W-1:0]  side_in;
        logic               val_in;
        logic [2:0][DW:0]   shifted;
        logic [2:0]         ge;
        logic [2:0][DW-1:0] rem_next;
        logic [2:0][QW-1:0] low_next;
        logic [2:0][QW-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = rem0;
            assign low_in  = low0;
            assign quo_in  = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
            assign val_in  = in_valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign low_in  = low_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign val_in  = val_reg[k-1];
        end

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                shifted[l]  = {rem_in[l], low_in[l][QW-1]};
                ge[l]       = shifted[l] >= {1'b0, den_in};
                rem_next[l] = ge[l] ? DW'(shifted[l] - {1'b0, den_in}) : DW'(shifted[l]);
                low_next[l] = low_in[l] << 1;
                quo_next[l] = {quo_in[l][QW-2:0], ge[l]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                val_reg[k] <= 1'b0;
            else if (en)
                val_reg[k] <= val_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_next;
                quo_reg[k]  <= quo_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = val_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

// ----- hw/rtl/sbc_back.sv -----
// Back stages: push scaling, sign and saturation, result assembly.
// Two register stages. Depends on sbc_pkg.
`timescale 1ns / 1ps

module sbc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [2:0][sbc_pkg::Q_W-1:0]      in_quo,
    input  sbc_pkg::dv_side_t                 in_side,
    output logic                              out_valid,
    output sbc_pkg::out_t                     out_data
);

    localparam int COORD_W = sbc_pkg::COORD_W;
    localparam int FRAC_W  = sbc_pkg::FRAC_W;
    localparam int PEN_W   = sbc_pkg::PEN_W;
    localparam int PROD_W  = sbc_pkg::PROD_W;
    localparam int NORM_W  = sbc_pkg::NORM_W;
    localparam int Q_W     = sbc_pkg::Q_W;

    localparam logic signed [PEN_W:0] PUSH_HI =
        {{(PEN_W + 2 - COORD_W){1'b0}}, {(COORD_W - 1){1'b1}}};
    localparam logic signed [PEN_W:0] PUSH_LO = ~PUSH_HI;

    logic [1:0] v_reg;

    // stage 1: products and signed inside push
    logic [PROD_W-1:0]       prod1_next [3];
    logic signed [PEN_W:0]   ipush1_next;
    logic [PROD_W-1:0]       prod1_reg [3];
    logic [2:0][Q_W-1:0]     quo1_reg;
    logic signed [PEN_W:0]   ipush1_reg;
    logic                    hit1_reg;
    logic                    inside1_reg;
    sbc_pkg::axis_t          ax1_reg;
    logic                    axpos1_reg;
    logic [2:0]              dneg1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            prod1_next[i] = PROD_W'(in_side.pen_out) * PROD_W'(in_quo[i]);
        ipush1_next = in_side.ax_pos ? (PEN_W + 1)'(in_side.pen_in)
                                     : -((PEN_W + 1)'(in_side.pen_in));
    end

    // stage 2: assemble the result
    logic signed [NORM_W-1:0]  nrm [3];
    logic signed [COORD_W-1:0] psh [3];
    logic [COORD_W-1:0]        pmag [3];
    logic signed [COORD_W-1:0] isat;
    sbc_pkg::out_t             out_next;
    sbc_pkg::out_t             out_data_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nrm[i]  = '0;
            psh[i]  = '0;
            pmag[i] = prod1_reg[i][FRAC_W +: COORD_W];
        end
        priority if (ipush1_reg > PUSH_HI)
            isat = COORD_W'(PUSH_HI);
        else if (ipush1_reg < PUSH_LO)
            isat = COORD_W'(PUSH_LO);
        else
            isat = COORD_W'(ipush1_reg);

        if (hit1_reg && inside1_reg)
        begin
            unique case (ax1_reg)
                sbc_pkg::AX_X:
                begin
                    nrm[0] = axpos1_reg ? sbc_pkg::NORM_ONE : -sbc_pkg::NORM_ONE;
                    psh[0] = isat;
                end
                sbc_pkg::AX_Y:
                begin
                    nrm[1] = axpos1_reg ? sbc_pkg::NORM_ONE : -sbc_pkg::NORM_ONE;
                    psh[1] = isat;
                end
                default:
                begin
                    nrm[2] = axpos1_reg ? sbc_pkg::NORM_ONE : -sbc_pkg::NORM_ONE;
                    psh[2] = isat;
                end
            endcase
        end
        else if (hit1_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nrm[i] = dneg1_reg[i] ? -$signed(NORM_W'(quo1_reg[i]))
                                      : $signed(NORM_W'(quo1_reg[i]));
                psh[i] = dneg1_reg[i] ? -$signed(pmag[i]) : $signed(pmag[i]);
            end
        end

        out_next.hit      = hit1_reg;
        out_next.normal_x = nrm[0];
        out_next.normal_y = nrm[1];
        out_next.normal_z = nrm[2];
        out_next.push_x   = psh[0];
        out_next.push_y   = psh[1];
        out_next.push_z   = psh[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                prod1_reg[i] <= prod1_next[i];
            quo1_reg     <= in_quo;
            ipush1_reg   <= ipush1_next;
            hit1_reg     <= in_side.hit;
            inside1_reg  <= in_side.in_box;
            ax1_reg      <= in_side.ax;
            axpos1_reg   <= in_side.ax_pos;
            dneg1_reg    <= in_side.d_neg;
            out_data_reg <= out_next;
        end
    end

    assign out_valid = v_reg[1];
    assign out_data  = out_data_reg;

endmodule
